/* rtl/core/color_sensor_frame_classifier_core_assert.svh */
// ----------------------------------------------------------------------------
// Color sensor frame classifier - assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef COLOR_SENSOR_FRAME_CLASSIFIER_CORE_ASSERT_SVH
`define COLOR_SENSOR_FRAME_CLASSIFIER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check a property on the rising clock edge, ignored while reset is asserted
`define CSFC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);
// check a property on every rising clock edge, reset included
`define CSFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CSFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSFC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/csfc_pkg.sv */
// ----------------------------------------------------------------------------
// Color sensor frame classifier - package
// Shared types, frame constants, register indexes and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csfc_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h5A;
	localparam logic [7:0] TYPE_RGB  = 8'h45;

	// frame byte offsets
	localparam logic [2:0] POS_START = 3'd0;
	localparam logic [2:0] POS_TYPE  = 3'd2;
	localparam logic [2:0] POS_RED   = 3'd4;
	localparam logic [2:0] POS_GREEN = 3'd5;
	localparam logic [2:0] POS_BLUE  = 3'd6;
	localparam logic [2:0] POS_CSUM  = 3'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_DIFF_MARGIN = 2'd0;
	localparam logic [1:0] CFG_HIGH_LEVEL  = 2'd1;
	localparam logic [1:0] CFG_GREEN_LEVEL = 2'd2;
	localparam logic [1:0] CFG_BLUE_MARGIN = 2'd3;

	// configuration reset values
	localparam logic [7:0] RST_DIFF_MARGIN = 8'd25;
	localparam logic [7:0] RST_HIGH_LEVEL  = 8'd190;
	localparam logic [7:0] RST_GREEN_LEVEL = 8'd200;
	localparam logic [7:0] RST_BLUE_MARGIN = 8'd30;

	// frame status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
	localparam logic [1:0] STATUS_BAD_CSUM = 2'd2;

	// color class codes
	localparam logic [1:0] CLASS_RED     = 2'd0;
	localparam logic [1:0] CLASS_GREEN   = 2'd1;
	localparam logic [1:0] CLASS_BLUE    = 2'd2;
	localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [7:0] diff_margin;
		logic [7:0] high_level;
		logic [7:0] green_level;
		logic [7:0] blue_margin;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic       done;
		logic [1:0] status;
	} frame_evt_t;

endpackage

`default_nettype wire

/* rtl/core/csfc_frame.sv */
// ----------------------------------------------------------------------------
// Color sensor frame classifier - frame collector
// Aligns on the sync byte, keeps the running sum and captures type and
// channel bytes; flags frame completion and its status.
// ----------------------------------------------------------------------------
`default_nettype none

module csfc_frame (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_en,
	input  wire logic [7:0]          rx_byte,
	output csfc_pkg::frame_evt_t     evt,
	output csfc_pkg::rgb_t           rgb
);

	logic [2:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] type_q;
	csfc_pkg::rgb_t rgb_q;

	logic drop;
	logic last;

	// a stray byte where a frame should start is dropped
	assign drop = (pos_q == csfc_pkg::POS_START) && (rx_byte != csfc_pkg::SYNC_BYTE);
	assign last = (pos_q == csfc_pkg::POS_CSUM);

	always_comb begin
		evt.done = byte_en && last;
		if (type_q != csfc_pkg::TYPE_RGB) begin
			evt.status = csfc_pkg::STATUS_BAD_TYPE;
		end else if (sum_q != rx_byte) begin
			evt.status = csfc_pkg::STATUS_BAD_CSUM;
		end else begin
			evt.status = csfc_pkg::STATUS_OK;
		end
	end

	assign rgb = rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
			sum_q <= 8'd0;
		end else if (byte_en && !drop) begin
			if (last) begin
				pos_q <= 3'd0;
				sum_q <= 8'd0;
			end else begin
				pos_q <= pos_q + 3'd1;
				sum_q <= sum_q + rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && !drop) begin
			case (pos_q)
				csfc_pkg::POS_TYPE:  type_q      <= rx_byte;
				csfc_pkg::POS_RED:   rgb_q.red   <= rx_byte;
				csfc_pkg::POS_GREEN: rgb_q.green <= rx_byte;
				csfc_pkg::POS_BLUE:  rgb_q.blue  <= rx_byte;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/csfc_classify.sv */
// ----------------------------------------------------------------------------
// Color sensor frame classifier - color classifier
// Margin and level rules over the three channel bytes, red first.
// ----------------------------------------------------------------------------
`default_nettype none

module csfc_classify (
	input  wire csfc_pkg::rgb_t rgb,
	input  wire csfc_pkg::cfg_t cfg,
	output logic [1:0]          color_class
);

	logic [8:0] r9, g9, b9;
	logic [8:0] r_m, g_m, b_m, r_bm;
	logic       red_hit, green_hit, blue_hit;

	// widen to nine bits so that value plus margin never wraps
	assign r9   = {1'b0, rgb.red};
	assign g9   = {1'b0, rgb.green};
	assign b9   = {1'b0, rgb.blue};
	assign r_m  = r9 + {1'b0, cfg.diff_margin};
	assign g_m  = g9 + {1'b0, cfg.diff_margin};
	assign b_m  = b9 + {1'b0, cfg.diff_margin};
	assign r_bm = r9 + {1'b0, cfg.blue_margin};

	assign red_hit = ((r9 > g_m) && (r9 > b_m)) ||
		((rgb.red > cfg.high_level) && (rgb.green < cfg.high_level) &&
		 (rgb.blue < cfg.high_level));

	assign green_hit = ((g9 > r_m) && (g9 > b_m)) ||
		((rgb.green > cfg.high_level) && (rgb.red < cfg.high_level) &&
		 (rgb.blue < cfg.high_level) && (rgb.green > cfg.green_level));

	assign blue_hit = ((rgb.blue >= rgb.green) && (b9 > r_bm)) ||
		((rgb.blue > cfg.high_level) && (rgb.red < cfg.high_level) &&
		 (rgb.green < cfg.high_level));

	always_comb begin
		if (red_hit) begin
			color_class = csfc_pkg::CLASS_RED;
		end else if (green_hit) begin
			color_class = csfc_pkg::CLASS_GREEN;
		end else if (blue_hit) begin
			color_class = csfc_pkg::CLASS_BLUE;
		end else begin
			color_class = csfc_pkg::CLASS_UNKNOWN;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/color_sensor_frame_classifier_core.sv */
// ----------------------------------------------------------------------------
// Color sensor frame classifier - top level
// Frames the sensor byte stream, checks type and checksum, classifies color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte): one received byte per
//   request. Bytes before a 0x5A start byte are dropped silently.
//   Output channel (out_valid / out_stall / result fields): one request per
//   8-byte frame, carrying status, the three channel bytes and the class.
//   The class reads unknown whenever the status is not valid.
//   Configuration: cfg_we writes cfg_data to register cfg_idx
//   (0 diff margin, 1 high level, 2 green level, 3 blue margin).
//   Throughput: one byte per cycle while no stalled result holds the
//   pipeline. A byte is held in the input register, and the frame's last
//   byte then reaches the result register. A stalled result holds the
//   result register; the input register then fills and in_stall rises
//   until the result is taken.
//   Reset: frame alignment, running sum and both pipeline registers clear,
//   configuration returns to 25 / 190 / 200 / 30.
// ----------------------------------------------------------------------------
`default_nettype none

module color_sensor_frame_classifier_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      frame_status,
	output logic [7:0]      red_level,
	output logic [7:0]      green_level_out,
	output logic [7:0]      blue_level,
	output logic [1:0]      color_class,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [7:0] cfg_data
);

	csfc_pkg::cfg_t       cfg_q;
	logic                 valid_s1;
	logic [7:0]           rx_byte_s1;
	logic                 advance;
	csfc_pkg::frame_evt_t evt;
	csfc_pkg::rgb_t       rgb;
	logic [1:0]           class_raw;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	csfc_pkg::rgb_t       rgb_q;
	logic [1:0]           class_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_margin <= csfc_pkg::RST_DIFF_MARGIN;
			cfg_q.high_level  <= csfc_pkg::RST_HIGH_LEVEL;
			cfg_q.green_level <= csfc_pkg::RST_GREEN_LEVEL;
			cfg_q.blue_margin <= csfc_pkg::RST_BLUE_MARGIN;
		end else if (cfg_we) begin
			case (cfg_idx)
				csfc_pkg::CFG_DIFF_MARGIN: cfg_q.diff_margin <= cfg_data;
				csfc_pkg::CFG_HIGH_LEVEL:  cfg_q.high_level  <= cfg_data;
				csfc_pkg::CFG_GREEN_LEVEL: cfg_q.green_level <= cfg_data;
				csfc_pkg::CFG_BLUE_MARGIN: cfg_q.blue_margin <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the pipeline unless a result waits on a stalled receiver
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	csfc_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (valid_s1 && advance),
		.rx_byte (rx_byte_s1),
		.evt     (evt),
		.rgb     (rgb)
	);

	csfc_classify u_classify (
		.rgb         (rgb),
		.cfg         (cfg_q),
		.color_class (class_raw)
	);

	// result register: load on frame completion, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= evt.done;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.done) begin
			status_q <= evt.status;
			rgb_q    <= rgb;
			class_q  <= (evt.status == csfc_pkg::STATUS_OK) ? class_raw
				: csfc_pkg::CLASS_UNKNOWN;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_status    = status_q;
	assign red_level       = rgb_q.red;
	assign green_level_out = rgb_q.green;
	assign blue_level      = rgb_q.blue;
	assign color_class     = class_q;

`include "color_sensor_frame_classifier_core_assert.svh"

	`CSFC_ASSERT(a_done_loads, clk, arst_n, evt.done |=> out_valid_q, "completed frame lost")
	`CSFC_ASSERT(a_bad_unknown, clk, arst_n, (out_valid_q && (status_q != csfc_pkg::STATUS_OK)) |-> (class_q == csfc_pkg::CLASS_UNKNOWN), "bad frame carries a color class")
	`CSFC_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid_q && out_stall), "input stalled without a held result")
	`CSFC_ASSERT_ALWAYS(a_status_code, clk, !arst_n || !out_valid_q || (status_q <= csfc_pkg::STATUS_BAD_CSUM), "undefined frame status")

endmodule

`default_nettype wire

/* sim/csfc_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color sensor frame result checker
// Tracks frame alignment, the running sum and the thresholds from the byte
// and register traffic it sees, works out each frame result, and compares
// the result channel against it in order.
// ----------------------------------------------------------------------------

module csfc_frame_checker
	import csfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] frame_status,
	input  logic [7:0] red_level,
	input  logic [7:0] green_level_out,
	input  logic [7:0] blue_level,
	input  logic [1:0] color_class,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         results_pending
);

	typedef struct packed {
		logic [1:0] status;
		rgb_t       levels;
		logic [1:0] color;
	} frame_result_t;

	cfg_t          thresholds;
	logic [2:0]    frame_pos;
	logic [7:0]    frame_sum;
	logic [7:0]    frame_type;
	rgb_t          frame_rgb;
	frame_result_t frames_due[$];
	int            mismatches;

	function automatic logic [1:0] classify_color(input rgb_t c, input cfg_t s);
		int r, g, b, dm, hl, gl, bm;
		r = int'(c.red);
		g = int'(c.green);
		b = int'(c.blue);
		dm = int'(s.diff_margin);
		hl = int'(s.high_level);
		gl = int'(s.green_level);
		bm = int'(s.blue_margin);
		if ((r - g > dm && r - b > dm) || (r > hl && g < hl && b < hl))
			return CLASS_RED;
		if ((g - r > dm && g - b > dm) || (g > hl && r < hl && b < hl && g > gl))
			return CLASS_GREEN;
		if ((b >= g && b > r + bm) || (b > hl && r < hl && g < hl))
			return CLASS_BLUE;
		return CLASS_UNKNOWN;
	endfunction

	// advance the frame state by one accepted byte; queue a result on byte 7
	task automatic advance_frame(input logic [7:0] b);
		frame_result_t res;
		if (frame_pos == POS_START && b != SYNC_BYTE)
			return;
		if (frame_pos != POS_CSUM) begin
			frame_sum = frame_sum + b;
			case (frame_pos)
			POS_TYPE:  frame_type = b;
			POS_RED:   frame_rgb.red = b;
			POS_GREEN: frame_rgb.green = b;
			POS_BLUE:  frame_rgb.blue = b;
			default: ;
			endcase
			frame_pos = frame_pos + 3'd1;
		end else begin
			if (frame_type != TYPE_RGB)
				res.status = STATUS_BAD_TYPE;
			else if (frame_sum != b)
				res.status = STATUS_BAD_CSUM;
			else
				res.status = STATUS_OK;
			res.levels = frame_rgb;
			res.color = (res.status == STATUS_OK) ? classify_color(frame_rgb, thresholds)
				: CLASS_UNKNOWN;
			frames_due.push_back(res);
			frame_pos = POS_START;
			frame_sum = '0;
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_result();
		frame_result_t due;
		if (frames_due.size() == 0) begin
			$error("unexpected frame result: status %0d red %0d green %0d blue %0d class %0d",
				frame_status, red_level, green_level_out, blue_level, color_class);
			mismatches++;
			return;
		end
		due = frames_due.pop_front();
		check_field("frame_status", {6'd0, due.status}, {6'd0, frame_status});
		check_field("red_level", due.levels.red, red_level);
		check_field("green_level_out", due.levels.green, green_level_out);
		check_field("blue_level", due.levels.blue, blue_level);
		check_field("color_class", {6'd0, due.color}, {6'd0, color_class});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresholds = '{RST_DIFF_MARGIN, RST_HIGH_LEVEL, RST_GREEN_LEVEL, RST_BLUE_MARGIN};
			frame_pos = POS_START;
			frame_sum = '0;
			frame_type = '0;
			frame_rgb = '0;
			frames_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
				CFG_DIFF_MARGIN: thresholds.diff_margin = cfg_data;
				CFG_HIGH_LEVEL:  thresholds.high_level = cfg_data;
				CFG_GREEN_LEVEL: thresholds.green_level = cfg_data;
				CFG_BLUE_MARGIN: thresholds.blue_margin = cfg_data;
				default: ;
				endcase
			end
			// retire before queuing so a result never meets its own frame
			if (out_valid && !out_stall)
				compare_result();
			if (in_valid && !in_stall)
				advance_frame(rx_byte);
		end
		fail_count <= mismatches;
		results_pending <= frames_due.size();
	end

endmodule

/* sim/color_sensor_frame_classifier_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color sensor frame classifier - testbench
// Feeds the classifier a byte stream of framed sensor reports mixed with
// line noise and broken frames, under several threshold settings, with
// random gaps on both channels; the frame checker beside the block predicts
// and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------

module color_sensor_frame_classifier_core_test;
	import csfc_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int SINK_HOLD_CYCLES = 80;
	// the checksum byte passes the input and result registers; leave some slack
	localparam int SETTLE_CYCLES    = 4;
	localparam int PHASE_BYTES      = 320;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] frame_status;
	logic [7:0] red_level;
	logic [7:0] green_level_out;
	logic [7:0] blue_level;
	logic [1:0] color_class;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_data;

	int   fail_total;
	int   results_pending;
	int   bytes_sent = 0;
	int   cycle_count = 0;
	bit   idling = 1'b0;
	bit   sink_hold_req = 1'b0;
	cfg_t live_cfg;

	color_sensor_frame_classifier_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_status(frame_status),
		.red_level(red_level),
		.green_level_out(green_level_out),
		.blue_level(blue_level),
		.color_class(color_class),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	csfc_frame_checker frame_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_status(frame_status),
		.red_level(red_level),
		.green_level_out(green_level_out),
		.blue_level(blue_level),
		.color_class(color_class),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.fail_count(fail_total),
		.results_pending(results_pending)
	);

	always #5 clk = ~clk;

	// Offer one byte as a request and hold it until the block takes it.
	// Called and returns at a falling edge. A random gap may come first
	// while idling is on.
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (idling && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Send a full 8-byte frame; a nonzero sum_skew corrupts the checksum byte.
	task automatic send_frame(input rgb_t c, input logic [7:0] type_b,
		input logic [7:0] sum_skew);
		logic [7:0] frame [8];
		logic [7:0] sum;
		frame[0] = SYNC_BYTE;
		frame[1] = 8'($urandom);
		frame[2] = type_b;
		frame[3] = 8'($urandom);
		frame[4] = c.red;
		frame[5] = c.green;
		frame[6] = c.blue;
		sum = '0;
		for (int i = 0; i < 7; i++)
			sum = sum + frame[i];
		frame[7] = sum + sum_skew;
		for (int i = 0; i < 8; i++)
			push_byte(frame[i]);
	endtask

	// Stop offering and hold until every queued frame result has come out,
	// then let the pipeline settle so a register write finds the block idle.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_settings(input cfg_t s);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_DIFF_MARGIN;
		cfg_data <= s.diff_margin;
		@(negedge clk);
		cfg_idx <= CFG_HIGH_LEVEL;
		cfg_data <= s.high_level;
		@(negedge clk);
		cfg_idx <= CFG_GREEN_LEVEL;
		cfg_data <= s.green_level;
		@(negedge clk);
		cfg_idx <= CFG_BLUE_MARGIN;
		cfg_data <= s.blue_margin;
		@(negedge clk);
		cfg_we <= 1'b0;
		live_cfg = s;
	endtask

	// Pick channel levels, mostly right at the edges of the current
	// thresholds so each class rule is hit on both sides.
	function automatic rgb_t pick_colors(input cfg_t s);
		rgb_t       c;
		logic [7:0] hi;
		logic [7:0] lo;
		c = rgb_t'(24'($urandom));
		case ($urandom_range(0, 5))
		1: begin
			// red ahead of both others by about the margin
			hi = (c.green > c.blue) ? c.green : c.blue;
			c.red = hi + s.diff_margin + 8'($urandom_range(0, 2));
		end
		2: begin
			hi = (c.red > c.blue) ? c.red : c.blue;
			c.green = hi + s.diff_margin + 8'($urandom_range(0, 2));
		end
		3: begin
			// blue over red by about the blue margin, green close to blue
			c.blue = c.red + s.blue_margin + 8'($urandom_range(0, 2));
			c.green = c.blue - 8'($urandom_range(0, 2)) + 8'($urandom_range(0, 1));
		end
		4: begin
			// one channel at or just over the high level, the others at or just under
			hi = s.high_level + 8'($urandom_range(0, 1));
			lo = s.high_level - 8'($urandom_range(0, 1));
			c = '{red: lo, green: lo, blue: lo};
			case ($urandom_range(0, 2))
			0: c.red = hi;
			1: c.green = $urandom_range(0, 1) ? hi
				: s.green_level + 8'($urandom_range(0, 1));
			default: c.blue = hi;
			endcase
		end
		5: begin
			c.red = s.high_level + 8'($urandom_range(0, 2)) - 8'd1;
			c.green = s.high_level + 8'($urandom_range(0, 2)) - 8'd1;
			c.blue = s.high_level + 8'($urandom_range(0, 2)) - 8'd1;
		end
		default: ;
		endcase
		return c;
	endfunction

	// One stretch of random traffic under one register setting. Mostly
	// well-formed frames; some carry a bad type or checksum, and now and
	// then line noise or a frame cut short breaks the alignment.
	task automatic run_phase(input cfg_t s, input bit with_idling, input bit hold_sink);
		int         start;
		int         roll;
		int         n;
		logic [7:0] bad_type;
		drain_results();
		apply_settings(s);
		idling = with_idling;
		if (hold_sink)
			sink_hold_req = 1'b1;
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) begin
			roll = $urandom_range(0, 19);
			do
				bad_type = 8'($urandom);
			while (bad_type == TYPE_RGB);
			if (roll == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) push_byte(8'($urandom));
			end else if (roll == 1) begin
				n = $urandom_range(1, 6);
				push_byte(SYNC_BYTE);
				repeat (n) push_byte(8'($urandom));
			end else if (roll == 2) begin
				send_frame(pick_colors(live_cfg), bad_type, 8'd0);
			end else if (roll == 3) begin
				send_frame(pick_colors(live_cfg), TYPE_RGB, 8'($urandom_range(1, 255)));
			end else if (roll == 4) begin
				send_frame(pick_colors(live_cfg), bad_type, 8'($urandom_range(1, 255)));
			end else begin
				send_frame(pick_colors(live_cfg), TYPE_RGB, 8'd0);
			end
		end
	endtask

	// Result side: random stall bursts while idling is on, and one long
	// hold-off on request so the block backs up into its input channel.
	initial begin
		int burst;
		out_stall = 1'b0;
		burst = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				out_stall <= 1'b1;
				repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
				sink_hold_req = 1'b0;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(0, 5);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: abort a run that hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		cfg_t mix;
		int   pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_DIFF_MARGIN;
		cfg_data = '0;
		live_cfg = '{RST_DIFF_MARGIN, RST_HIGH_LEVEL, RST_GREEN_LEVEL, RST_BLUE_MARGIN};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: stray bytes before any start byte are dropped, then a
		// clean red frame at the level extremes, a frame with both the type
		// and the checksum wrong (type wins), and a checksum error alone.
		push_byte(8'h00);
		push_byte(8'hFF);
		send_frame('{red: 8'hFF, green: 8'h00, blue: 8'h00}, TYPE_RGB, 8'd0);
		send_frame('{red: 8'h10, green: 8'hF0, blue: 8'h20}, 8'h00, 8'd1);
		send_frame('{red: 8'h00, green: 8'h00, blue: 8'hFF}, TYPE_RGB, 8'hFF);

		// Random: reset thresholds with a long receiver hold-off, then both
		// extremes, then random and mixed settings; the last stretch runs
		// without idling.
		run_phase(live_cfg, 1'b1, 1'b1);
		run_phase('0, 1'b1, 1'b0);
		run_phase('1, 1'b0, 1'b0);
		run_phase(cfg_t'($urandom), 1'b1, 1'b0);
		for (int i = 0; i < 4; i++) begin
			pick = $urandom_range(0, 2);
			mix[i * 8 +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
		end
		run_phase(mix, 1'b1, 1'b0);
		run_phase(cfg_t'($urandom), 1'b0, 1'b0);

		drain_results();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (fail_total == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
